@@ rtl/ffha_pkg.sv @@
// Package with the constants, header type and codes of the first-fit heap allocator.
package ffha_pkg;

   localparam int HEAP_BYTES   = 4096;
   localparam int ALIGN_BYTES  = 8;
   localparam int HEADER_BYTES = 8;

   localparam int GRAN_COUNT = HEAP_BYTES / ALIGN_BYTES;
   localparam int GRAN_W     = 9;
   localparam int SIZE_W     = 13;
   localparam int CNT_W      = 10;
   localparam int EFF_HDR    = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int END_ADDR   = ((HEAP_BYTES - EFF_HDR) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int END_GRAN   = END_ADDR / ALIGN_BYTES;

   localparam logic [GRAN_W-1:0] END_GRAN_G = GRAN_W'(END_GRAN);
   localparam logic [SIZE_W-1:0] END_SIZE   = SIZE_W'(END_ADDR);

   typedef struct packed {
      logic              alloc;
      logic [GRAN_W-1:0] next;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   localparam int HDR_W = $bits(hdr_type);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_DONE       = 2'd0;
   localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [1:0] ST_FREE_IGN   = 2'd2;

endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/first_fit_heap_allocator_core.sv @@
// Top level of the first-fit heap allocator: sequencer, header store and result register.
// An allocate walks the free list to the first block that is large enough; a split also
// walks the free blocks below the tail to insert it and then relinks.
// A free walks the free blocks below it and relinks a lower block that it does not join;
// a request refused at its check skips the walks. One transaction is in work at a time.
// After reset a clearing pass sweeps the header store; no request is taken then.
module first_fit_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // request_bytes[12:0], release_addr[24:13], zeros
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // block_addr, status, free_bytes, low_water_bytes,
                                   // percent_free, zeros
);

   localparam int GW = ffha_pkg::GRAN_W;
   localparam int SW = ffha_pkg::SIZE_W;

   typedef enum logic [13:0] {
      S_CLEAR  = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_A_CHK  = 14'b00000000000100,
      S_A_UNL  = 14'b00000000001000,
      S_A_SPL  = 14'b00000000010000,
      S_A_FIN  = 14'b00000000100000,
      S_F_CHK  = 14'b00000001000000,
      S_P_ST   = 14'b00000010000000,
      S_P_WALK = 14'b00000100000000,
      S_P_MRG  = 14'b00001000000000,
      S_P_NXT  = 14'b00010000000000,
      S_P_LNK  = 14'b00100000000000,
      S_DONE   = 14'b01000000000000,
      S_RESP   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [GW-1:0] clr_ff, clr_in;
   logic [GW-1:0] head_ff, head_in;
   logic [SW-1:0] free_ff, free_in, low_ff, low_in;
   logic          cmd_ff, cmd_in;
   logic [SW-1:0] wanted_ff, wanted_in;
   logic [GW-1:0] blk_ff, blk_in, prev_ff, prev_in, g_ff, g_in, it_ff, it_in, nx_ff, nx_in;
   logic [GW-1:0] mblk_ff, mblk_in;
   ffha_pkg::hdr_type blk_hdr_ff, blk_hdr_in, prev_hdr_ff, prev_hdr_in;
   ffha_pkg::hdr_type g_hdr_ff, g_hdr_in, it_hdr_ff, it_hdr_in;
   logic          prev_head_ff, prev_head_in, it_head_ff, it_head_in;
   logic [ffha_pkg::CNT_W-1:0] n_ff, n_in;
   logic [SW-1:0] msize_ff, msize_in;
   logic          malloc_ff, malloc_in;
   logic [11:0]   out_addr_ff, out_addr_in;
   logic [1:0]    out_status_ff, out_status_in;
   logic [6:0]    pct_ff, pct_in;

   logic          mem_we;
   logic [GW-1:0] mem_waddr, mem_raddr;
   ffha_pkg::hdr_type mem_wdata, rd_hdr;
   logic [ffha_pkg::HDR_W-1:0] mem_rdata;

   logic [12:0]   req_bytes;
   logic [11:0]   rel_addr;
   logic [13:0]   wanted_sum;
   logic [13:0]   wanted_full;
   logic [GW-1:0] rel_g;
   logic [SW-1:0] rem_size;
   logic [10:0]   ng_sum;
   logic [13:0]   it_end, mblk_end;
   logic [SW-1:0] msize_sum;
   logic [19:0]   pct_prod;

   assign req_bytes   = req_tdata[12:0];
   assign rel_addr    = req_tdata[24:13];
   assign wanted_sum  = {1'b0, req_bytes} + 14'(ffha_pkg::EFF_HDR + ffha_pkg::ALIGN_BYTES - 1);
   assign wanted_full = {wanted_sum[13:3], 3'b000};
   assign rel_g       = rel_addr[11:3] - 9'd1;
   assign rd_hdr      = ffha_pkg::hdr_type'(mem_rdata);
   assign rem_size    = blk_hdr_ff.size - wanted_ff;
   assign ng_sum      = {2'b00, blk_ff} + {1'b0, wanted_ff[12:3]};
   assign it_end      = {2'b00, it_ff, 3'b000} + {1'b0, it_hdr_ff.size};
   assign mblk_end    = {2'b00, mblk_ff, 3'b000} + {1'b0, msize_ff};
   assign msize_sum   = msize_ff + rd_hdr.size;
   assign pct_prod    = 20'(free_ff) * 20'd100;

   ffha_ram #(
      .WIDTH(ffha_pkg::HDR_W),
      .DEPTH(ffha_pkg::GRAN_COUNT)
   ) u_hdr_ram (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      low_in        = low_ff;
      cmd_in        = cmd_ff;
      wanted_in     = wanted_ff;
      blk_in        = blk_ff;
      prev_in       = prev_ff;
      g_in          = g_ff;
      it_in         = it_ff;
      nx_in         = nx_ff;
      mblk_in       = mblk_ff;
      blk_hdr_in    = blk_hdr_ff;
      prev_hdr_in   = prev_hdr_ff;
      g_hdr_in      = g_hdr_ff;
      it_hdr_in     = it_hdr_ff;
      prev_head_in  = prev_head_ff;
      it_head_in    = it_head_ff;
      n_in          = n_ff;
      msize_in      = msize_ff;
      malloc_in     = malloc_ff;
      out_addr_in   = out_addr_ff;
      out_status_in = out_status_ff;
      pct_in        = pct_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == '0) begin
               mem_wdata = '{alloc: 1'b0, next: ffha_pkg::END_GRAN_G, size: ffha_pkg::END_SIZE};
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == GW'(ffha_pkg::GRAN_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in        = req_tuser;
               out_addr_in   = '0;
               out_status_in = ffha_pkg::ST_ALLOC_FAIL;
               if (req_tuser == ffha_pkg::CMD_ALLOC) begin
                  wanted_in    = wanted_full[SW-1:0];
                  blk_in       = head_ff;
                  prev_head_in = 1'b1;
                  n_in         = '0;
                  mem_raddr    = head_ff;
                  if (req_bytes == '0 || wanted_full > {1'b0, free_ff} ||
                      head_ff == ffha_pkg::END_GRAN_G) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_A_CHK;
                  end
               end else begin
                  out_status_in = ffha_pkg::ST_FREE_IGN;
                  g_in          = rel_g;
                  mem_raddr     = rel_g;
                  if (rel_addr < 12'(ffha_pkg::EFF_HDR) || rel_addr[2:0] != 3'b000 ||
                      rel_g >= ffha_pkg::END_GRAN_G) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_F_CHK;
                  end
               end
            end
         end
         S_A_CHK: begin
            blk_hdr_in = rd_hdr;
            if (rd_hdr.size >= wanted_ff) begin
               state_in = S_A_UNL;
            end else if (n_ff == ffha_pkg::CNT_W'(ffha_pkg::GRAN_COUNT) ||
                         rd_hdr.next == ffha_pkg::END_GRAN_G) begin
               state_in = S_DONE;
            end else begin
               prev_in      = blk_ff;
               prev_hdr_in  = rd_hdr;
               prev_head_in = 1'b0;
               blk_in       = rd_hdr.next;
               n_in         = n_ff + 1'b1;
               mem_raddr    = rd_hdr.next;
            end
         end
         S_A_UNL: begin
            if (prev_head_ff) begin
               head_in = blk_hdr_ff.next;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = prev_ff;
               mem_wdata = '{alloc: prev_hdr_ff.alloc, next: blk_hdr_ff.next,
                             size: prev_hdr_ff.size};
            end
            if (rem_size > SW'(2 * ffha_pkg::EFF_HDR) &&
                ng_sum < 11'(ffha_pkg::GRAN_COUNT)) begin
               state_in = S_A_SPL;
            end else begin
               state_in = S_A_FIN;
            end
         end
         S_A_SPL: begin
            mem_we          = 1'b1;
            mem_waddr       = ng_sum[GW-1:0];
            mem_wdata       = '{alloc: 1'b0, next: ffha_pkg::END_GRAN_G, size: rem_size};
            g_in            = ng_sum[GW-1:0];
            g_hdr_in        = mem_wdata;
            blk_hdr_in.size = wanted_ff;
            state_in        = S_P_ST;
         end
         S_A_FIN: begin
            mem_we        = 1'b1;
            mem_waddr     = blk_ff;
            mem_wdata     = '{alloc: 1'b1, next: '0, size: blk_hdr_ff.size};
            free_in       = (blk_hdr_ff.size > free_ff) ? '0 : free_ff - blk_hdr_ff.size;
            if (free_in < low_ff) begin
               low_in = free_in;
            end
            out_addr_in   = {blk_ff, 3'b000} + 12'(ffha_pkg::EFF_HDR);
            out_status_in = ffha_pkg::ST_DONE;
            state_in      = S_DONE;
         end
         S_F_CHK: begin
            if (!rd_hdr.alloc) begin
               state_in = S_DONE;
            end else begin
               g_hdr_in       = rd_hdr;
               g_hdr_in.alloc = 1'b0;
               mem_we         = 1'b1;
               mem_waddr      = g_ff;
               mem_wdata      = g_hdr_in;
               free_in        = free_ff + rd_hdr.size;
               state_in       = S_P_ST;
            end
         end
         S_P_ST: begin
            mem_raddr = head_ff;
            if (head_ff >= g_ff) begin
               it_head_in = 1'b1;
               nx_in      = head_ff;
               state_in   = S_P_MRG;
            end else begin
               it_head_in = 1'b0;
               it_in      = head_ff;
               n_in       = ffha_pkg::CNT_W'(1);
               state_in   = S_P_WALK;
            end
         end
         S_P_WALK: begin
            if (n_ff == ffha_pkg::CNT_W'(ffha_pkg::GRAN_COUNT) || rd_hdr.next >= g_ff) begin
               it_hdr_in = rd_hdr;
               nx_in     = rd_hdr.next;
               state_in  = S_P_MRG;
            end else begin
               it_in     = rd_hdr.next;
               n_in      = n_ff + 1'b1;
               mem_raddr = rd_hdr.next;
            end
         end
         S_P_MRG: begin
            mem_raddr = nx_ff;
            if (!it_head_ff && it_end == {2'b00, g_ff, 3'b000}) begin
               mblk_in   = it_ff;
               msize_in  = it_hdr_ff.size + g_hdr_ff.size;
               malloc_in = it_hdr_ff.alloc;
            end else begin
               mblk_in   = g_ff;
               msize_in  = g_hdr_ff.size;
               malloc_in = g_hdr_ff.alloc;
            end
            state_in = S_P_NXT;
         end
         S_P_NXT: begin
            mem_we    = 1'b1;
            mem_waddr = mblk_ff;
            mem_wdata = '{alloc: malloc_ff, next: nx_ff, size: msize_ff};
            if (mblk_end == {2'b00, nx_ff, 3'b000}) begin
               if (nx_ff != ffha_pkg::END_GRAN_G) begin
                  mem_wdata.size = msize_sum;
                  mem_wdata.next = rd_hdr.next;
               end else begin
                  mem_wdata.next = ffha_pkg::END_GRAN_G;
               end
            end
            if (it_head_ff) begin
               head_in = mblk_ff;
            end
            if (!it_head_ff && it_ff != mblk_ff) begin
               state_in = S_P_LNK;
            end else if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               state_in = S_A_FIN;
            end else begin
               out_status_in = ffha_pkg::ST_DONE;
               state_in      = S_DONE;
            end
         end
         S_P_LNK: begin
            mem_we    = 1'b1;
            mem_waddr = it_ff;
            mem_wdata = '{alloc: it_hdr_ff.alloc, next: mblk_ff, size: it_hdr_ff.size};
            if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               state_in = S_A_FIN;
            end else begin
               out_status_in = ffha_pkg::ST_DONE;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            pct_in   = pct_prod[18:12];
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         head_ff  <= '0;
         free_ff  <= ffha_pkg::END_SIZE;
         low_ff   <= ffha_pkg::END_SIZE;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         low_ff   <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      wanted_ff     <= wanted_in;
      blk_ff        <= blk_in;
      prev_ff       <= prev_in;
      g_ff          <= g_in;
      it_ff         <= it_in;
      nx_ff         <= nx_in;
      mblk_ff       <= mblk_in;
      blk_hdr_ff    <= blk_hdr_in;
      prev_hdr_ff   <= prev_hdr_in;
      g_hdr_ff      <= g_hdr_in;
      it_hdr_ff     <= it_hdr_in;
      prev_head_ff  <= prev_head_in;
      it_head_ff    <= it_head_in;
      n_ff          <= n_in;
      msize_ff      <= msize_in;
      malloc_ff     <= malloc_in;
      out_addr_ff   <= out_addr_in;
      out_status_ff <= out_status_in;
      pct_ff        <= pct_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {1'b0, pct_ff, low_ff, free_ff, out_status_ff, out_addr_ff};

endmodule

@@ rtl/ffha_chk.sv @@
// Port checker for the first-fit heap allocator, bound to the top level.
module ffha_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:12] <= ffha_pkg::ST_FREE_IGN)
      else $error("unknown status code");

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13:12] != ffha_pkg::ST_DONE |-> rsp_tdata[11:0] == 12'd0)
      else $error("address given with a failed transaction");

   a_low_water: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:27] <= rsp_tdata[26:14])
      else $error("low-water mark above free bytes");

endmodule

bind first_fit_heap_allocator_core ffha_chk u_ffha_chk (.*);

@@ tb/sv/first_fit_heap_allocator_core_checker.sv @@
// Checker for the heap allocator: tracks the heap and compares each response transaction.
module first_fit_heap_allocator_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int          fail_count,
   output int          pending,
   output int          allocs_done,
   output int          frees_done,
   output int          requests_refused
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_HEAD = 1024;

   typedef struct packed {
      logic [6:0]  percent_free;
      logic [12:0] low_water_bytes;
      logic [12:0] free_bytes;
      logic [1:0]  status;
      logic [11:0] block_addr;
   } outcome_type;

   int unsigned blk_size [ffha_pkg::GRAN_COUNT];
   int unsigned blk_next [ffha_pkg::GRAN_COUNT];
   bit          blk_used [ffha_pkg::GRAN_COUNT];
   int unsigned first_free;
   int unsigned heap_free;
   int unsigned heap_low;
   outcome_type outcomes [$];

   function automatic int unsigned clamp_link(int unsigned v);
      return (v < ffha_pkg::GRAN_COUNT) ? v : ffha_pkg::END_GRAN;
   endfunction

   function automatic int unsigned follow(int unsigned node);
      if (node == LIST_HEAD) return clamp_link(first_free);
      if (node >= ffha_pkg::GRAN_COUNT) return ffha_pkg::END_GRAN;
      return clamp_link(blk_next[node]);
   endfunction

   task automatic relink(int unsigned node, int unsigned v);
      if (node == LIST_HEAD) first_free = v;
      else if (node < ffha_pkg::GRAN_COUNT) blk_next[node] = v;
   endtask

   task automatic insert_free(int unsigned g);
      int unsigned it, nx, blk, n;
      it = LIST_HEAD;
      n = 0;
      if (g >= ffha_pkg::GRAN_COUNT) return;
      while (n < ffha_pkg::GRAN_COUNT) begin
         nx = follow(it);
         if (nx >= g) break;
         it = nx;
         n++;
      end
      blk = g;
      if (it != LIST_HEAD &&
          it * ffha_pkg::ALIGN_BYTES + blk_size[it] == g * ffha_pkg::ALIGN_BYTES) begin
         blk_size[it] += blk_size[g];
         blk = it;
      end
      nx = follow(it);
      if (blk * ffha_pkg::ALIGN_BYTES + blk_size[blk] == nx * ffha_pkg::ALIGN_BYTES) begin
         if (nx != ffha_pkg::END_GRAN) begin
            blk_size[blk] += blk_size[nx];
            blk_next[blk] = clamp_link(blk_next[nx]);
         end else begin
            blk_next[blk] = ffha_pkg::END_GRAN;
         end
      end else begin
         blk_next[blk] = nx;
      end
      if (it != blk) relink(it, blk);
   endtask

   task automatic allocate(input int unsigned req, output int unsigned addr,
                           output logic [1:0] st);
      int unsigned wanted, prev, blk, n, ng;
      st = ffha_pkg::ST_ALLOC_FAIL;
      addr = 0;
      prev = LIST_HEAD;
      n = 0;
      if (req == 0) return;
      wanted = req + ffha_pkg::EFF_HDR;
      if (wanted % ffha_pkg::ALIGN_BYTES != 0)
         wanted += ffha_pkg::ALIGN_BYTES - wanted % ffha_pkg::ALIGN_BYTES;
      if (wanted > heap_free) return;
      blk = follow(LIST_HEAD);
      while (blk != ffha_pkg::END_GRAN && blk_size[blk] < wanted &&
             n < ffha_pkg::GRAN_COUNT) begin
         prev = blk;
         blk = follow(blk);
         n++;
      end
      if (blk == ffha_pkg::END_GRAN || blk_size[blk] < wanted) return;
      relink(prev, follow(blk));
      if (blk_size[blk] - wanted > 2 * ffha_pkg::EFF_HDR) begin
         ng = blk + wanted / ffha_pkg::ALIGN_BYTES;
         if (ng < ffha_pkg::GRAN_COUNT) begin
            blk_size[ng] = blk_size[blk] - wanted;
            blk_used[ng] = 1'b0;
            blk_next[ng] = ffha_pkg::END_GRAN;
            blk_size[blk] = wanted;
            insert_free(ng);
         end
      end
      heap_free = (blk_size[blk] > heap_free) ? 0 : heap_free - blk_size[blk];
      if (heap_free < heap_low) heap_low = heap_free;
      blk_used[blk] = 1'b1;
      blk_next[blk] = 0;
      st = ffha_pkg::ST_DONE;
      addr = blk * ffha_pkg::ALIGN_BYTES + ffha_pkg::EFF_HDR;
   endtask

   task automatic release_block(input int unsigned addr, output logic [1:0] st);
      int unsigned g;
      st = ffha_pkg::ST_FREE_IGN;
      if (addr < ffha_pkg::EFF_HDR || (addr - ffha_pkg::EFF_HDR) % ffha_pkg::ALIGN_BYTES != 0)
         return;
      g = (addr - ffha_pkg::EFF_HDR) / ffha_pkg::ALIGN_BYTES;
      if (g >= ffha_pkg::GRAN_COUNT || g >= ffha_pkg::END_GRAN) return;
      if (!blk_used[g]) return;
      blk_used[g] = 1'b0;
      heap_free += blk_size[g];
      insert_free(g);
      st = ffha_pkg::ST_DONE;
   endtask

   task automatic load_empty_heap();
      foreach (blk_size[i]) begin
         blk_size[i] = 0;
         blk_next[i] = 0;
         blk_used[i] = 1'b0;
      end
      blk_size[0] = ffha_pkg::END_ADDR;
      blk_next[0] = ffha_pkg::END_GRAN;
      first_free = 0;
      heap_free = ffha_pkg::END_ADDR;
      heap_low = ffha_pkg::END_ADDR;
   endtask

   task automatic predict(input logic cmd, input logic [12:0] bytes, input logic [11:0] rel);
      outcome_type o;
      int unsigned addr;
      logic [1:0] st;
      addr = 0;
      if (cmd == ffha_pkg::CMD_ALLOC) allocate(bytes, addr, st);
      else release_block(rel, st);
      o.block_addr = addr[11:0];
      o.status = st;
      o.free_bytes = heap_free[12:0];
      o.low_water_bytes = heap_low[12:0];
      o.percent_free = 7'((heap_free * 100) / ffha_pkg::HEAP_BYTES);
      outcomes.push_back(o);
      if (st == ffha_pkg::ST_DONE && cmd == ffha_pkg::CMD_ALLOC) allocs_done++;
      else if (st == ffha_pkg::ST_DONE) frees_done++;
      else requests_refused++;
   endtask

   initial begin
      fail_count = 0;
      allocs_done = 0;
      frees_done = 0;
      requests_refused = 0;
      load_empty_heap();
   end

   assign pending = outcomes.size();

   always @(posedge clock) begin
      outcome_type want, got;
      if (reset) begin
         load_empty_heap();
         outcomes.delete();
      end else begin
         if (req_tvalid && req_tready) predict(req_tuser, req_tdata[12:0], req_tdata[24:13]);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[46:0];
            if (outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("Unexpected response transaction %h", got);
            end else begin
               want = outcomes.pop_front();
               if (got != want || rsp_tdata[47] !== 1'b0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"Mismatch: addr %0d/%0d st %0d/%0d free %0d/%0d",
                               " low %0d/%0d pct %0d/%0d"},
                              want.block_addr, got.block_addr, want.status, got.status,
                              want.free_bytes, got.free_bytes, want.low_water_bytes,
                              got.low_water_bytes, want.percent_free, got.percent_free);
               end
            end
         end
      end
   end

endmodule

@@ tb/sv/first_fit_heap_allocator_core_tb.sv @@
// Top of the heap allocator testbench: clock, reset, stimulus and verdict.
module first_fit_heap_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   int          fail_count, pending, allocs_done, frees_done, requests_refused;
   int          cycles = 0;
   int          items_sent = 0;
   bit          sender_quiet = 1'b0;
   logic [11:0] live_addrs [$];

   first_fit_heap_allocator_core uut (.*);

   first_fit_heap_allocator_core_checker checker_i (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out with %0d transactions outstanding.", pending);
         $display("** first_fit_heap_allocator_core: FAILED **");
         $finish;
      end
      if (rsp_tvalid && rsp_tready && rsp_tdata[13:12] == ffha_pkg::ST_DONE &&
          rsp_tdata[11:0] != 0)
         live_addrs.push_back(rsp_tdata[11:0]);
   end

   initial begin
      int n;
      n = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (n >= 3000 && n < 3400) rsp_tready <= 1'b0;
         else if (n >= 6000 && n < 9000) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(99) >= 8);
         n++;
         @(negedge clock);
      end
   end

   task automatic send(input logic cmd, input logic [12:0] bytes, input logic [11:0] rel);
      while (!sender_quiet && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, rel, bytes};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_random();
      int r, k;
      logic [11:0] a;
      r = $urandom_range(99);
      if (r < 55 || live_addrs.size() == 0) begin
         k = $urandom_range(99);
         if (k < 80) send(ffha_pkg::CMD_ALLOC, 13'($urandom_range(1, 200)), 12'($urandom));
         else if (k < 95) send(ffha_pkg::CMD_ALLOC, 13'($urandom_range(1, 4096)), 12'($urandom));
         else send(ffha_pkg::CMD_ALLOC, 13'($urandom), 12'($urandom));
      end else if (r < 93) begin
         k = $urandom_range(live_addrs.size() - 1);
         a = live_addrs[k];
         live_addrs.delete(k);
         send(ffha_pkg::CMD_FREE, 13'($urandom), a);
      end else begin
         send(ffha_pkg::CMD_FREE, 13'($urandom), 12'($urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send(ffha_pkg::CMD_ALLOC, 13'd0, 12'd0);
      send(ffha_pkg::CMD_ALLOC, 13'd4096, 12'hFFF);
      send(ffha_pkg::CMD_ALLOC, 13'h1FFF, 12'd0);
      send(ffha_pkg::CMD_ALLOC, 13'd4080, 12'd0);
      send(ffha_pkg::CMD_ALLOC, 13'd1, 12'd0);
      send(ffha_pkg::CMD_FREE, 13'h1FFF, 12'd8);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd8);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd0);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd4);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd13);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'hFFF);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd4088);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd4080);
      send(ffha_pkg::CMD_ALLOC, 13'd1, 12'd0);
      send(ffha_pkg::CMD_ALLOC, 13'd100, 12'd0);
      send(ffha_pkg::CMD_ALLOC, 13'd16, 12'd0);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd32);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd24);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd8);
      send(ffha_pkg::CMD_ALLOC, 13'd3000, 12'd0);
      send(ffha_pkg::CMD_ALLOC, 13'd1064, 12'd0);
      send(ffha_pkg::CMD_FREE, 13'd0, 12'd8);
      live_addrs.delete();
      for (int i = 0; i < 500; i++) begin
         sender_quiet = (i >= 200 && i < 300);
         send_random();
      end
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      $display("Sent %0d request transactions: %0d allocations and %0d frees done,",
               items_sent, allocs_done, frees_done);
      $display("%0d requests refused or ignored, with a long response stall on the way.",
               requests_refused);
      if (fail_count == 0) begin
         $display("** first_fit_heap_allocator_core: PASSED **");
      end else begin
         $display("** first_fit_heap_allocator_core: FAILED **");
      end
      $finish;
   end

endmodule
